>>> rtl/mmh3_pkg.sv
// Shared constants and types for the MurmurHash3 x64 128 stream hash.
`default_nettype none
package mmh3_pkg;
   localparam logic [63:0] MIX_C1   = 64'h87c37b91114253d5;
   localparam logic [63:0] MIX_C2   = 64'h4cf5ad432745937f;
   localparam logic [63:0] LANE_ADD1 = 64'h0000000052dce729;
   localparam logic [63:0] LANE_ADD2 = 64'h0000000038495ab5;
   localparam logic [63:0] FIN_M1   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FIN_M2   = 64'hc4ceb9fe1a85ec53;

   // Datapath operation codes issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,   // latch request, merge bytes into carry buffer
      OP_LOADK,    // load block words into the key registers
      OP_LOADT,    // load tail words into the key registers
      OP_MULA,     // form partial products of target times constant
      OP_MULB,     // sum partial products into target, rotate keys on request
      OP_LANE1A,   // xor/rotate/add lane one
      OP_LANE1B,   // lane one times five plus constant
      OP_LANE2A,   // xor/rotate/add lane two
      OP_LANE2B,   // lane two times five plus constant
      OP_TAILXOR,  // fold tail keys into lanes
      OP_LEN,      // fold length into lanes, lane_one += lane_two
      OP_XADD2,    // lane_two += lane_one
      OP_FSHIFT,   // v ^= v >> 33
      OP_XADD1,    // lane_one += lane_two
      OP_FINISH    // capture digest, restart the message
   } op_type;

   // Register that a multiply, shift or rotate works on.
   typedef enum logic [1:0] {
      SEL_K1,
      SEL_K2,
      SEL_LANE1,
      SEL_LANE2
   } sel_type;

   // Constant operand of a multiply.
   typedef enum logic [1:0] {
      CONST_C1,
      CONST_C2,
      CONST_M1,
      CONST_M2
   } const_type;

   typedef struct packed {
      op_type     op;
      sel_type    target;
      const_type  mconst;
      logic       rot;        // rotate key after the multiply
   } cmd_type;

   typedef struct packed {
      logic full_block;
      logic last;
   } stat_type;

   function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (64 - n));
   endfunction
endpackage
`default_nettype wire

>>> rtl/mmh3_stream_if.sv
// Valid/ready stream interface carrying a generic payload.
`default_nettype none
interface mmh3_stream_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mmh3_datapath.sv
// Datapath: carry buffer, lanes, length counter and shared multiplier.
`default_nettype none
module mmh3_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire mmh3_pkg::cmd_type cmd,
   output mmh3_pkg::stat_type   stat,
   input  wire logic [63:0]     in_low,
   input  wire logic [63:0]     in_high,
   input  wire logic [4:0]      in_count,
   input  wire logic            in_last,
   input  wire logic            seed_we,
   input  wire logic [31:0]     seed_data,
   output logic [63:0]          hash_one,
   output logic [63:0]          hash_two
);
   logic [31:0]  seed_ff;
   logic [63:0]  lane1_ff, lane2_ff, len_ff, k1_ff, k2_ff;
   logic [119:0] pend_ff;
   logic [3:0]   pcnt_ff;
   logic [127:0] blk_ff;
   logic         full_ff, last_ff;
   logic [63:0]  pp_lo_ff;
   logic [31:0]  pp_cross_ff;
   logic [63:0]  seed_wide;
   logic [247:0] merged;
   logic [127:0] item, pend_vis;
   logic [4:0]   cnt;
   logic [5:0]   have;
   logic [63:0]  tail_lo, tail_hi;
   logic [63:0]  mul_a, mul_b, prod_ll, mul_res, mul_out;
   logic [31:0]  prod_lh, prod_hl;

   assign seed_wide = {{32{seed_ff[31]}}, seed_ff};
   assign cnt = in_count[4] ? 5'd16 : in_count;
   assign have = {2'b0, pcnt_ff} + {1'b0, cnt};

   // Only carry bytes below the count are live; the rest read as zero.
   always_comb begin
      pend_vis = 128'b0;
      for (int i = 0; i < 15; i++)
         if (4'(i) < pcnt_ff) pend_vis[i*8 +: 8] = pend_ff[i*8 +: 8];
   end

   always_comb begin
      item = {in_high, in_low};
      for (int i = 0; i < 16; i++)
         if (5'(i) >= cnt) item[i*8 +: 8] = 8'h0;
      merged = {120'b0, pend_vis} | ({120'b0, item} << {pcnt_ff, 3'b0});
   end

   // Tail bytes live in the carry buffer, masked to its count.
   assign tail_lo = pend_vis[63:0];
   assign tail_hi = pend_vis[127:64];

   // 64x64 multiply, low half, split into 32x32 partial products, registered, then summed.
   always_comb begin
      unique case (cmd.target)
         mmh3_pkg::SEL_K1:    mul_a = k1_ff;
         mmh3_pkg::SEL_K2:    mul_a = k2_ff;
         mmh3_pkg::SEL_LANE1: mul_a = lane1_ff;
         mmh3_pkg::SEL_LANE2: mul_a = lane2_ff;
      endcase
      unique case (cmd.mconst)
         mmh3_pkg::CONST_C1: mul_b = mmh3_pkg::MIX_C1;
         mmh3_pkg::CONST_C2: mul_b = mmh3_pkg::MIX_C2;
         mmh3_pkg::CONST_M1: mul_b = mmh3_pkg::FIN_M1;
         mmh3_pkg::CONST_M2: mul_b = mmh3_pkg::FIN_M2;
      endcase
   end

   assign prod_ll = 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
   assign prod_lh = mul_a[31:0] * mul_b[63:32];
   assign prod_hl = mul_a[63:32] * mul_b[31:0];
   assign mul_res = pp_lo_ff + {pp_cross_ff, 32'b0};

   always_comb begin
      mul_out = mul_res;
      if (cmd.rot) begin
         if (cmd.target == mmh3_pkg::SEL_K1) mul_out = mmh3_pkg::rotl(mul_res, 31);
         else mul_out = mmh3_pkg::rotl(mul_res, 33);
      end
   end

   assign stat.full_block = full_ff;
   assign stat.last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'b0;
         lane1_ff <= 64'b0;
         lane2_ff <= 64'b0;
         len_ff <= 64'b0;
         pcnt_ff <= 4'b0;
         full_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         if (seed_we) begin
            seed_ff <= seed_data;
            if (len_ff == 64'b0 && pcnt_ff == 4'b0) begin
               lane1_ff <= {{32{seed_data[31]}}, seed_data};
               lane2_ff <= {{32{seed_data[31]}}, seed_data};
            end
         end
         unique case (cmd.op)
            mmh3_pkg::OP_ACCEPT: begin
               len_ff <= len_ff + {59'b0, cnt};
               last_ff <= in_last;
               full_ff <= have[4];
               blk_ff <= merged[127:0];
               if (have[4]) pend_ff <= merged[247:128];
               else pend_ff <= merged[119:0];
               pcnt_ff <= have[3:0];
            end
            mmh3_pkg::OP_LOADK: begin
               k1_ff <= blk_ff[63:0];
               k2_ff <= blk_ff[127:64];
            end
            mmh3_pkg::OP_LOADT: begin
               k1_ff <= tail_lo;
               k2_ff <= tail_hi;
            end
            mmh3_pkg::OP_MULA: begin
               pp_lo_ff <= prod_ll;
               pp_cross_ff <= prod_lh + prod_hl;
            end
            mmh3_pkg::OP_MULB:
               unique case (cmd.target)
                  mmh3_pkg::SEL_K1:    k1_ff <= mul_out;
                  mmh3_pkg::SEL_K2:    k2_ff <= mul_out;
                  mmh3_pkg::SEL_LANE1: lane1_ff <= mul_out;
                  mmh3_pkg::SEL_LANE2: lane2_ff <= mul_out;
               endcase
            mmh3_pkg::OP_LANE1A: lane1_ff <= mmh3_pkg::rotl(lane1_ff ^ k1_ff, 27) + lane2_ff;
            mmh3_pkg::OP_LANE1B: lane1_ff <= (lane1_ff << 2) + lane1_ff + mmh3_pkg::LANE_ADD1;
            mmh3_pkg::OP_LANE2A: lane2_ff <= mmh3_pkg::rotl(lane2_ff ^ k2_ff, 31) + lane1_ff;
            mmh3_pkg::OP_LANE2B: lane2_ff <= (lane2_ff << 2) + lane2_ff + mmh3_pkg::LANE_ADD2;
            mmh3_pkg::OP_TAILXOR: begin
               // Zero tail words contribute nothing, so fold unconditionally.
               lane1_ff <= lane1_ff ^ k1_ff;
               lane2_ff <= lane2_ff ^ k2_ff;
            end
            mmh3_pkg::OP_LEN: begin
               lane1_ff <= (lane1_ff ^ len_ff) + (lane2_ff ^ len_ff);
               lane2_ff <= lane2_ff ^ len_ff;
            end
            mmh3_pkg::OP_XADD2: lane2_ff <= lane2_ff + lane1_ff;
            mmh3_pkg::OP_FSHIFT:
               if (cmd.target == mmh3_pkg::SEL_LANE2) lane2_ff <= lane2_ff ^ (lane2_ff >> 33);
               else lane1_ff <= lane1_ff ^ (lane1_ff >> 33);
            mmh3_pkg::OP_XADD1: lane1_ff <= lane1_ff + lane2_ff;
            mmh3_pkg::OP_FINISH: begin
               hash_one <= lane1_ff;
               hash_two <= lane2_ff + lane1_ff;
               // Digest done: restart the message.
               lane1_ff <= seed_wide;
               lane2_ff <= seed_wide;
               len_ff <= 64'b0;
               pcnt_ff <= 4'b0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/mmh3_control.sv
// Controller: sequences block mixing and finalization, owns the handshakes.
`default_nettype none
module mmh3_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire mmh3_pkg::stat_type stat,
   output mmh3_pkg::cmd_type      cmd
);
   typedef enum logic [5:0] {
      S_IDLE, S_DEC, S_LOADK,
      S_K1A, S_K1B, S_K1C, S_K1D, S_K2A, S_K2B, S_K2C, S_K2D,
      S_L1A, S_L1B, S_L2A, S_L2B,
      S_LOADT, S_TXOR, S_LEN, S_XB,
      S_F1S1, S_F1A1, S_F1B1, S_F1S2, S_F1A2, S_F1B2, S_F1S3,
      S_F2S1, S_F2A1, S_F2B1, S_F2S2, S_F2A2, S_F2B2, S_F2S3,
      S_XA1, S_FIN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      tail_ff;
   logic      fin_go;

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == S_IDLE);
   // Hold the finished digest until the response register is free.
   assign fin_go = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd.op = mmh3_pkg::OP_NONE;
      cmd.target = mmh3_pkg::SEL_K1;
      cmd.mconst = mmh3_pkg::CONST_C1;
      cmd.rot = 1'b0;
      unique case (state_ff)
         S_IDLE:  if (req_valid && req_ready) cmd.op = mmh3_pkg::OP_ACCEPT;
         S_LOADK: cmd.op = mmh3_pkg::OP_LOADK;
         S_LOADT: cmd.op = mmh3_pkg::OP_LOADT;
         S_K1A: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.mconst = mmh3_pkg::CONST_C1;
         end
         S_K1B: begin
            cmd.op = mmh3_pkg::OP_MULB;
            cmd.rot = 1'b1;
         end
         S_K1C: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.mconst = mmh3_pkg::CONST_C2;
         end
         S_K1D: cmd.op = mmh3_pkg::OP_MULB;
         S_K2A: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.target = mmh3_pkg::SEL_K2;
            cmd.mconst = mmh3_pkg::CONST_C2;
         end
         S_K2B: begin
            cmd.op = mmh3_pkg::OP_MULB;
            cmd.target = mmh3_pkg::SEL_K2;
            cmd.rot = 1'b1;
         end
         S_K2C: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.target = mmh3_pkg::SEL_K2;
            cmd.mconst = mmh3_pkg::CONST_C1;
         end
         S_K2D: begin
            cmd.op = mmh3_pkg::OP_MULB;
            cmd.target = mmh3_pkg::SEL_K2;
         end
         S_L1A:  cmd.op = mmh3_pkg::OP_LANE1A;
         S_L1B:  cmd.op = mmh3_pkg::OP_LANE1B;
         S_L2A:  cmd.op = mmh3_pkg::OP_LANE2A;
         S_L2B:  cmd.op = mmh3_pkg::OP_LANE2B;
         S_TXOR: cmd.op = mmh3_pkg::OP_TAILXOR;
         S_LEN:  cmd.op = mmh3_pkg::OP_LEN;
         S_XB:   cmd.op = mmh3_pkg::OP_XADD2;
         S_F1S1, S_F1S2, S_F1S3: begin
            cmd.op = mmh3_pkg::OP_FSHIFT;
            cmd.target = mmh3_pkg::SEL_LANE1;
         end
         S_F1A1: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.target = mmh3_pkg::SEL_LANE1;
            cmd.mconst = mmh3_pkg::CONST_M1;
         end
         S_F1A2: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.target = mmh3_pkg::SEL_LANE1;
            cmd.mconst = mmh3_pkg::CONST_M2;
         end
         S_F1B1, S_F1B2: begin
            cmd.op = mmh3_pkg::OP_MULB;
            cmd.target = mmh3_pkg::SEL_LANE1;
         end
         S_F2S1, S_F2S2, S_F2S3: begin
            cmd.op = mmh3_pkg::OP_FSHIFT;
            cmd.target = mmh3_pkg::SEL_LANE2;
         end
         S_F2A1: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.target = mmh3_pkg::SEL_LANE2;
            cmd.mconst = mmh3_pkg::CONST_M1;
         end
         S_F2A2: begin
            cmd.op = mmh3_pkg::OP_MULA;
            cmd.target = mmh3_pkg::SEL_LANE2;
            cmd.mconst = mmh3_pkg::CONST_M2;
         end
         S_F2B1, S_F2B2: begin
            cmd.op = mmh3_pkg::OP_MULB;
            cmd.target = mmh3_pkg::SEL_LANE2;
         end
         S_XA1:  cmd.op = mmh3_pkg::OP_XADD1;
         S_FIN:  if (fin_go) cmd.op = mmh3_pkg::OP_FINISH;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tail_ff <= 1'b0;
      end else begin
         if (fin_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) state_ff <= S_DEC;
            S_DEC:
               priority if (stat.full_block) state_ff <= S_LOADK;
               else if (stat.last) state_ff <= S_LOADT;
               else state_ff <= S_IDLE;
            S_LOADK: begin
               tail_ff <= 1'b0;
               state_ff <= S_K1A;
            end
            S_LOADT: begin
               tail_ff <= 1'b1;
               state_ff <= S_K1A;
            end
            S_K1A: state_ff <= S_K1B;
            S_K1B: state_ff <= S_K1C;
            S_K1C: state_ff <= S_K1D;
            S_K1D: state_ff <= S_K2A;
            S_K2A: state_ff <= S_K2B;
            S_K2B: state_ff <= S_K2C;
            S_K2C: state_ff <= S_K2D;
            S_K2D: state_ff <= tail_ff ? S_TXOR : S_L1A;
            S_L1A: state_ff <= S_L1B;
            S_L1B: state_ff <= S_L2A;
            S_L2A: state_ff <= S_L2B;
            S_L2B: state_ff <= stat.last ? S_LOADT : S_IDLE;
            S_TXOR: state_ff <= S_LEN;
            S_LEN: state_ff <= S_XB;
            S_XB: state_ff <= S_F1S1;
            S_F1S1: state_ff <= S_F1A1;
            S_F1A1: state_ff <= S_F1B1;
            S_F1B1: state_ff <= S_F1S2;
            S_F1S2: state_ff <= S_F1A2;
            S_F1A2: state_ff <= S_F1B2;
            S_F1B2: state_ff <= S_F1S3;
            S_F1S3: state_ff <= S_F2S1;
            S_F2S1: state_ff <= S_F2A1;
            S_F2A1: state_ff <= S_F2B1;
            S_F2B1: state_ff <= S_F2S2;
            S_F2S2: state_ff <= S_F2A2;
            S_F2A2: state_ff <= S_F2B2;
            S_F2B2: state_ff <= S_F2S3;
            S_F2S3: state_ff <= S_XA1;
            S_XA1: state_ff <= S_FIN;
            S_FIN: if (fin_go) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/murmur3_x64_128_stream_hash.sv
// Top level of the streaming MurmurHash3 x64 128-bit engine.
// Takes one request of up to 16 bytes at a time and returns the 128-bit digest
// after the request marked last. A request that completes a 16-byte block runs
// four 64-bit multiplies, every one through one shared unit (three 32x32
// partial products, registered, then their sum), plus four lane update steps;
// a request without a full block only merges its bytes into the carry buffer.
// The last request adds finalization (tail keys, length fold, two fmix64 chains
// through the same multiplier) before the digest is loaded into the response
// register; if an earlier digest still waits there, finalization holds until
// it is taken. The seed may be written only while the engine is idle.
`default_nettype none
module murmur3_x64_128_stream_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   mmh3_stream_if.sink      req,
   mmh3_stream_if.source    rsp,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);
   mmh3_pkg::cmd_type  cmd;
   mmh3_pkg::stat_type stat;
   logic [63:0]        hash_one, hash_two;

   // Payload layout: {last, byte_count, bytes_high, bytes_low}.
   mmh3_control u_control (
      .clock, .reset,
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat, .cmd
   );

   mmh3_datapath u_datapath (
      .clock, .reset, .cmd, .stat,
      .in_low    (req.data[63:0]),
      .in_high   (req.data[127:64]),
      .in_count  (req.data[132:128]),
      .in_last   (req.data[133]),
      .seed_we   (csr_we),
      .seed_data (csr_wdata),
      .hash_one, .hash_two
   );

   assign rsp.data = {hash_two, hash_one};
endmodule
`default_nettype wire

>>> bench/tb_murmur3_x64_128_stream_hash.sv
// Self-checking bench for the streaming MurmurHash3 x64 128 engine.
`timescale 1ns / 100ps
module tb_murmur3_x64_128_stream_hash;

   localparam int REQ_W = 134;
   localparam int RSP_W = 128;
   localparam int SETTLE = 40;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  cnt;
      logic        last;
      logic        known;
      logic [63:0] h1;
      logic [63:0] h2;
   } vec_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   mmh3_stream_if #(.Width(REQ_W)) req_if ();
   mmh3_stream_if #(.Width(RSP_W)) rsp_if ();

   murmur3_x64_128_stream_hash u_top (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [31:0] seed_q;
   logic [63:0] lane_a, lane_b, msg_len;
   logic [7:0]  carry [15];
   int unsigned carry_n;

   logic [63:0] digest_h1 [$];
   logic [63:0] digest_h2 [$];
   int errors = 0;
   int digests_seen = 0;
   int requests_sent = 0;
   longint cycles = 0;
   bit quiet = 0;
   int stall_left = 0;

   function automatic logic [63:0] rot64(logic [63:0] v, int n);
      return (v << n) | (v >> (64 - n));
   endfunction

   function automatic logic [63:0] fmix(logic [63:0] v);
      v ^= v >> 33;
      v *= 64'hff51afd7ed558ccd;
      v ^= v >> 33;
      v *= 64'hc4ceb9fe1a85ec53;
      v ^= v >> 33;
      return v;
   endfunction

   function automatic logic [63:0] scramble_a(logic [63:0] k);
      return rot64(k * mmh3_pkg::MIX_C1, 31) * mmh3_pkg::MIX_C2;
   endfunction

   function automatic logic [63:0] scramble_b(logic [63:0] k);
      return rot64(k * mmh3_pkg::MIX_C2, 33) * mmh3_pkg::MIX_C1;
   endfunction

   function automatic logic [63:0] wide_seed();
      return {{32{seed_q[31]}}, seed_q};
   endfunction

   function automatic void restart_message();
      lane_a = wide_seed();
      lane_b = wide_seed();
      msg_len = '0;
      carry_n = 0;
   endfunction

   function automatic void write_seed(logic [31:0] s);
      seed_q = s;
      if (msg_len == 0 && carry_n == 0) begin
         lane_a = wide_seed();
         lane_b = wide_seed();
      end
   endfunction

   // Advance the hash state by one request; push a digest on last.
   function automatic void hash_request(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt,
                                        logic last, logic known, logic [63:0] k1,
                                        logic [63:0] k2);
      logic [7:0]  buf_b [32];
      logic [63:0] w0, w1, t0, t1;
      int unsigned n, fill;
      n = (cnt > 16) ? 16 : cnt;
      for (int i = 0; i < 32; i++) buf_b[i] = '0;
      for (int i = 0; i < carry_n; i++) buf_b[i] = carry[i];
      for (int i = 0; i < n; i++)
         buf_b[carry_n + i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
      fill = carry_n + n;
      msg_len += n;
      if (fill >= 16) begin
         w0 = '0;
         w1 = '0;
         for (int i = 0; i < 8; i++) begin
            w0[8*i +: 8] = buf_b[i];
            w1[8*i +: 8] = buf_b[8+i];
         end
         lane_a ^= scramble_a(w0);
         lane_a = rot64(lane_a, 27) + lane_b;
         lane_a = lane_a * 5 + mmh3_pkg::LANE_ADD1;
         lane_b ^= scramble_b(w1);
         lane_b = rot64(lane_b, 31) + lane_a;
         lane_b = lane_b * 5 + mmh3_pkg::LANE_ADD2;
         fill -= 16;
         for (int i = 0; i < fill; i++) buf_b[i] = buf_b[16 + i];
         for (int i = fill; i < 16; i++) buf_b[i] = '0;
      end
      for (int i = 0; i < fill; i++) carry[i] = buf_b[i];
      carry_n = fill;
      if (!last) return;
      t0 = '0;
      t1 = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < fill) t0[8*i +: 8] = buf_b[i];
         if (i + 8 < fill) t1[8*i +: 8] = buf_b[8+i];
      end
      if (fill > 8) lane_b ^= scramble_b(t1);
      if (fill > 0) lane_a ^= scramble_a(t0);
      lane_a ^= msg_len;
      lane_b ^= msg_len;
      lane_a += lane_b;
      lane_b += lane_a;
      lane_a = fmix(lane_a);
      lane_b = fmix(lane_b);
      lane_a += lane_b;
      lane_b += lane_a;
      if (known && (k1 !== lane_a || k2 !== lane_b)) begin
         errors++;
         $display("%0t: table digest %h_%h disagrees with prediction %h_%h",
                  $realtime, k2, k1, lane_b, lane_a);
      end
      digest_h1.push_back(lane_a);
      digest_h2.push_back(lane_b);
      restart_message();
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         digests_seen++;
         if (digest_h1.size() == 0) begin
            errors++;
            $display("%0t: unexpected digest, expected none, got %h", $realtime, rsp_if.data);
         end else begin
            if (rsp_if.data[63:0] !== digest_h1[0]) begin
               errors++;
               $display("%0t: hash_first expected %h got %h", $realtime, digest_h1[0],
                        rsp_if.data[63:0]);
            end
            if (rsp_if.data[127:64] !== digest_h2[0]) begin
               errors++;
               $display("%0t: hash_second expected %h got %h", $realtime, digest_h2[0],
                        rsp_if.data[127:64]);
            end
            void'(digest_h1.pop_front());
            void'(digest_h2.pop_front());
         end
      end
   end

   task automatic send_request(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic last,
                               logic known = 1'b0, logic [63:0] k1 = '0, logic [63:0] k2 = '0);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {last, cnt, hi, lo};
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
      hash_request(lo, hi, cnt, last, known, k1, k2);
   endtask

   // Drain, let the engine settle, then write the seed.
   task automatic program_seed(logic [31:0] s);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (digest_h1.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= s;
      @(posedge clock);
      write_seed(s);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_message(int parts);
      logic [4:0] cnt;
      for (int p = 0; p < parts; p++) begin
         case ($urandom_range(0, 9))
            0: cnt = 5'd16;
            1: cnt = 5'd0;
            2: cnt = 5'($urandom_range(17, 31));
            default: cnt = 5'($urandom_range(0, 16));
         endcase
         send_request(rand64(), rand64(), cnt, p == parts - 1);
      end
   endtask

   vec_row_type table_rows [] = '{
      '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 64'h0, 64'h0},
      '{64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 64'h0, 64'h0},
      '{'1, '1, 5'd16, 1'b1, 1'b0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 5'd16, 1'b1, 1'b0, 64'h0, 64'h0},
      '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b1, 1'b0, 64'h0, 64'h0},
      '{64'h00000000000000a5, 64'h0, 5'd1, 1'b1, 1'b0, 64'h0, 64'h0},
      '{'1, 64'h0, 5'd8, 1'b1, 1'b0, 64'h0, 64'h0},
      '{'1, 64'hff, 5'd9, 1'b1, 1'b0, 64'h0, 64'h0},
      '{'1, '1, 5'd15, 1'b1, 1'b0, 64'h0, 64'h0},
      '{64'h1111111111111111, 64'h2222222222222222, 5'd7, 1'b0, 1'b0, 64'h0, 64'h0},
      '{64'h3333333333333333, 64'h4444444444444444, 5'd12, 1'b0, 1'b0, 64'h0, 64'h0},
      '{64'h5555555555555555, 64'h6666666666666666, 5'd16, 1'b0, 1'b0, 64'h0, 64'h0},
      '{64'haaaaaaaaaaaaaaaa, 64'hbbbbbbbbbbbbbbbb, 5'd0, 1'b1, 1'b0, 64'h0, 64'h0},
      '{64'h8000000000000001, 64'h8000000000000001, 5'd17, 1'b0, 1'b0, 64'h0, 64'h0},
      '{64'h7fffffffffffffff, 64'h7fffffffffffffff, 5'd3, 1'b1, 1'b0, 64'h0, 64'h0}
   };

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b1;
      seed_q = '0;
      for (int i = 0; i < 15; i++) carry[i] = '0;
      restart_message();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (table_rows[i])
         send_request(table_rows[i].lo, table_rows[i].hi, table_rows[i].cnt, table_rows[i].last,
                      table_rows[i].known, table_rows[i].h1, table_rows[i].h2);

      // seed corners, then random seeds; every second phase also rewrites mid-message
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: program_seed(32'hffffffff);
            1: program_seed(32'h80000000);
            2: program_seed(32'h7fffffff);
            3: program_seed(32'h00000000);
            default: program_seed($urandom);
         endcase
         if (ph == 0) send_request('0, '0, 5'd0, 1'b1);
         if (ph % 2 == 1) begin
            random_message($urandom_range(1, 3) + 1);
            send_request(rand64(), rand64(), 5'($urandom_range(1, 15)), 1'b0);
            program_seed($urandom);
            random_message($urandom_range(1, 4));
         end
         if (ph == 10) quiet = 1;
         while (requests_sent < 110 * (ph + 1)) begin
            if ($urandom_range(0, 3) == 0) random_message($urandom_range(1, 12));
            else random_message($urandom_range(1, 4));
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (digest_h1.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d requests over twelve seed settings, checked %0d digests",
               requests_sent, digests_seen);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
